// ===== design/prf_pkg.sv =====
package prf_pkg;

    // Trial division starts at the smallest prime and its square.
    localparam int unsigned FIRST_DIVISOR = 2;
    localparam int unsigned FIRST_SQUARE  = FIRST_DIVISOR * FIRST_DIVISOR;

endpackage

// ===== design/prime_reject_filter_top.sv =====
// Channel   Direction  Fields (lowest bit first)      Handshake
// s_axis    in         tdata: value, zero padding     tvalid / tready
// m_axis    out        tdata: kept_value, zero pad.   tvalid / tready
//
// An item whose magnitude is below two skips the search; otherwise its run time
// grows with k, the number of trial divisors examined; at 32 bits the worst case
// is a prime near 2^31 with about 46340 divisors. The bit-serial remainder unit
// sets the pace: one quotient bit per cycle, with all DATA_WIDTH dividend bits
// brought down for each divisor.
// i_rst_n is synchronous and active low; it clears the sequencer and the
// output valid flag. The input is refused while an item is being tested, and
// a waiting result is held in the output register while the next item is
// accepted; a stalled output only delays the end of the following item.
module prime_reject_filter_top #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // value in the low DATA_WIDTH bits, zeros above
    input  logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // kept_value in the low DATA_WIDTH bits, zeros above
    output logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    import prf_pkg::*;

    localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
    // The divisor never exceeds the square root of 2^DATA_WIDTH plus one.
    localparam int D_W     = (DATA_WIDTH + 1) / 2 + 1;
    // Square of the divisor: one bit more than the magnitude.
    localparam int SQ_W    = DATA_WIDTH + 1;
    localparam int CNT_W   = $clog2(DATA_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_DIV,
        S_STEP,
        S_EMIT
    } t_state;

    t_state                  r_state;
    logic [DATA_WIDTH-1:0]   r_value;   // item as received
    logic [DATA_WIDTH-1:0]   r_mag;     // its magnitude, unsigned
    logic [DATA_WIDTH-1:0]   r_shift;   // dividend bits still to be brought down
    logic [D_W-1:0]          r_d;       // current trial divisor
    logic [SQ_W-1:0]         r_sq;      // square of the trial divisor
    logic [D_W-1:0]          r_rem;     // partial remainder, always below r_d
    logic [CNT_W-1:0]        r_cnt;     // dividend bits left minus one
    logic [DATA_WIDTH-1:0]   r_kept;
    logic                    r_out_valid;

    logic [DATA_WIDTH-1:0]   in_value;
    logic [DATA_WIDTH-1:0]   in_mag;
    logic [D_W:0]            trial;
    logic                    trial_ge;
    logic [D_W:0]            trial_diff;
    logic [SQ_W-1:0]         n_sq;
    logic                    out_free;

    assign in_value = s_axis_tdata[DATA_WIDTH-1:0];
    // The negation wraps the most negative value onto itself, which read as
    // unsigned is exactly its magnitude.
    assign in_mag   = in_value[DATA_WIDTH-1] ? (~in_value + 1'b1) : in_value;

    // The restoring step brings down one dividend bit and subtracts the
    // divisor when it fits.
    assign trial      = {r_rem, r_shift[DATA_WIDTH-1]};
    assign trial_ge   = (trial >= {1'b0, r_d});
    assign trial_diff = trial - {1'b0, r_d};

    // (d + 1)^2 = d^2 + 2d + 1
    assign n_sq = r_sq + SQ_W'({r_d, 1'b1});

    assign out_free = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_kept);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // The emit state drives the flag itself.
            if (r_out_valid && m_axis_tready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_value <= in_value;
                        r_mag   <= in_mag;
                        r_d     <= D_W'(FIRST_DIVISOR);
                        r_sq    <= SQ_W'(FIRST_SQUARE);
                        // Zero and one are not prime and skip the search.
                        if (in_mag < DATA_WIDTH'(FIRST_DIVISOR)) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_TEST;
                        end
                    end
                end
                S_TEST: begin
                    if (r_sq > {1'b0, r_mag}) begin
                        // No divisor up to the square root: prime, dropped.
                        r_state <= S_IDLE;
                    end else begin
                        r_shift <= r_mag;
                        r_rem   <= '0;
                        r_cnt   <= CNT_W'(DATA_WIDTH - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem   <= trial_ge ? trial_diff[D_W-1:0] : trial[D_W-1:0];
                    r_shift <= {r_shift[DATA_WIDTH-2:0], 1'b0};
                    r_cnt   <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (r_rem == '0) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_d     <= r_d + 1'b1;
                        r_sq    <= n_sq;
                        r_state <= S_TEST;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_kept      <= r_value;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // The partial remainder must stay below the divisor throughout a division.
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_d))
        else $error("partial remainder not below divisor");

    // The running square must track the divisor at every bound check.
    a_square_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TEST) |->
            (r_sq == SQ_W'(SQ_W'(r_d) * SQ_W'(r_d))))
        else $error("running square out of step with divisor");

    // A divisor below two would make every magnitude look composite.
    a_divisor_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_STEP) |->
            (r_d >= D_W'(FIRST_DIVISOR)))
        else $error("trial divisor below two");

    // A result is only loaded from the emit state.
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid ##1 r_out_valid) |-> ($past(r_state) == S_EMIT))
        else $error("result produced outside the emit state");
`endif

endmodule

// ===== dv/testbench.sv =====
module testbench;

    import prf_pkg::*;

    localparam int DW          = 32;
    localparam int TDATA_W     = ((DW + 7) / 8) * 8;
    // The slowest correct run is set by the largest positive value, a prime that needs the
    // longest search on its own. Every other item has a bounded smallest factor or a bounded
    // magnitude. The limit is several times the slowest correct run.
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int HOLD_CYCLES = 1500;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    // value, then zero padding
    logic [TDATA_W-1:0] s_axis_tdata  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // kept_value, then zero padding
    logic [TDATA_W-1:0] m_axis_tdata;

    // Values that the filter should pass on, oldest first.
    logic [DW-1:0] kept_queue[$];
    int unsigned   fault_count      = 0;
    int unsigned   cycle_count      = 0;
    // Predicted run time of the item accepted most recently. It sets the quiet time
    // after the last result, since a prime may still be under test at that point.
    int unsigned   last_item_cycles = 0;
    // Idling controls. The steady flags switch the random gaps off on their side.
    // The hold counter belongs to the receiver process, which counts it down.
    bit            tx_steady        = 1'b0;
    bit            rx_steady        = 1'b0;
    int unsigned   hold_left        = 0;
    int unsigned   stall_left       = 0;

    prime_reject_filter_top #(
        .DATA_WIDTH(DW)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Returns 1 when the magnitude of the value is not prime, so that the value is kept.
    // The trial count is the number of divisors examined, which sets the block's run time.
    function automatic bit value_is_kept(input logic [DW-1:0] value,
                                         output int unsigned trials);
        logic [DW-1:0] neg;
        logic [63:0]   mag;
        logic [63:0]   divisor;
        neg    = -value;
        // The most negative value wraps to itself, which is its full magnitude.
        mag    = value[DW-1] ? {{(64 - DW){1'b0}}, neg} : {{(64 - DW){1'b0}}, value};
        trials = 0;
        if (mag < 2) begin
            return 1'b1;
        end
        for (divisor = FIRST_DIVISOR; divisor <= mag / divisor; divisor++) begin
            trials++;
            if (mag % divisor == 0) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Random values are shaped so that each takes little time in the block. Primes are
    // only reached at small or medium magnitudes. Wide values always carry a small factor.
    function automatic logic [DW-1:0] draw_value();
        int unsigned   pick;
        int unsigned   factor;
        logic [DW-1:0] mag;
        pick = $urandom_range(9, 0);
        case (pick)
            0, 1, 2, 3, 4: begin
                mag = $urandom_range(4095, 0);
            end
            5, 6: begin
                mag = $urandom_range(1 << 20, 4096);
            end
            7, 8: begin
                factor = $urandom_range(13, 2);
                mag    = factor * $urandom_range(32'h8000_0000 / factor, 1);
            end
            default: begin
                mag = $urandom & ~32'd1;
            end
        endcase
        return $urandom_range(1, 0) ? -mag : mag;
    endfunction

    // Offers one item and returns at the clock edge that accepted it. After acceptance the
    // valid flag is left alone, so a following item can be offered in the same step.
    task automatic send_value(input logic [DW-1:0] value);
        int unsigned gap;
        int unsigned trials;
        gap = tx_steady ? 0 : $urandom_range(16, 0);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'(value);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (value_is_kept(value, trials)) begin
            kept_queue.push_back(value);
        end
        last_item_cycles = 2 + trials * (DW + 2);
    endtask

    // Stops the sender and waits until every kept value has come back. It then waits out
    // the run time of the last item, because that item may be a prime still under test.
    task automatic drain_results();
        int unsigned tail;
        s_axis_tvalid <= 1'b0;
        while (kept_queue.size() != 0) @(posedge i_clk);
        tail = last_item_cycles + 64;
        repeat (tail) @(posedge i_clk);
    endtask

    // This covers zero, plus and minus one, both ends of the range and the most negative
    // value. It also covers small primes, squares of primes at the loop bound and wide patterns.
    task automatic test_corner_values();
        logic [DW-1:0] corners[$];
        corners = '{32'd0, 32'd1, -32'sd1, 32'd2, -32'sd2, 32'd3, -32'sd3, 32'd4,
                    -32'sd4, 32'd9, 32'd25, 32'd49, 32'd15, 32'd97, -32'sd97,
                    32'd63001, 32'd65521, 32'd65536, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h8000_0002, 32'h7FFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA};
        foreach (corners[i]) begin
            send_value(corners[i]);
        end
        drain_results();
    endtask

    // This is the main random stream, with idle gaps drawn on both sides.
    task automatic test_random_stream();
        repeat (55) begin
            send_value(draw_value());
        end
        drain_results();
    endtask

    // The receiver refuses results for a long stretch while the sender keeps offering
    // kept values. One result waits in the output register, the next one finishes
    // behind it, and then the input has to stall.
    task automatic test_output_backpressure();
        @(negedge i_clk);
        hold_left = HOLD_CYCLES;
        tx_steady = 1'b1;
        @(posedge i_clk);
        repeat (8) begin
            send_value(-(DW'(4) * DW'($urandom_range(1000, 1))));
        end
        tx_steady = 1'b0;
        drain_results();
    endtask

    // A run with no idling on either side, so that items and results follow back to back.
    task automatic test_steady_stream();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        repeat (15) begin
            send_value(draw_value());
        end
        drain_results();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // The receiver compares each accepted result with the oldest kept value. It then
    // draws a fresh stall; a long hold-off, while it runs, takes priority over it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (kept_queue.size() == 0) begin
                    $display("%0t: kept_value expected none, got %h", $time,
                             m_axis_tdata[DW-1:0]);
                    fault_count++;
                end else if (m_axis_tdata[DW-1:0] !== kept_queue[0]) begin
                    $display("%0t: kept_value expected %h, got %h", $time, kept_queue[0],
                             m_axis_tdata[DW-1:0]);
                    fault_count++;
                    void'(kept_queue.pop_front());
                end else begin
                    void'(kept_queue.pop_front());
                end
                stall_left = rx_steady ? 0 : $urandom_range(16, 0);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // This watchdog ends a run that hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("prime_reject_filter_top: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_values();
        test_random_stream();
        test_output_backpressure();
        test_steady_stream();
        if (fault_count == 0) begin
            $display("prime_reject_filter_top: match");
        end else begin
            $display("prime_reject_filter_top: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/prf_pkg.sv
design/prime_reject_filter_top.sv
dv/testbench.sv
